>>> rtl/dda_line_pixel_generator_macros.svh
// assertion macros for the line pixel generator
`ifndef DDA_LINE_PIXEL_GENERATOR_MACROS_SVH
`define DDA_LINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define DLPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DLPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dda_pkg.sv
// shared types and constants for the line pixel generator
package dda_pkg;

    localparam int COORD_W   = 24;
    localparam int COLOR_W   = 32;
    localparam int OFFSET_W  = 32;
    localparam int PITCH_W   = 16;
    localparam int PBITS_W   = 7;
    localparam int BYTE_SH   = 3;
    localparam int STRIDE_W  = PBITS_W - BYTE_SH;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS = 1'b1;

    localparam logic [PITCH_W-1:0] ROW_PITCH_RST  = 16'd4096;
    localparam logic [PBITS_W-1:0] PIXEL_BITS_RST = 7'd32;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 1024;
    localparam int FRAC_BITS_DEF     = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    // status of a bit-serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } ser_stat_t;

endpackage

>>> rtl/dda_line_pixel_generator.sv
// top level of the dda line pixel generator
// start transaction: accept, then the bit-serial step division, then back to idle; the next transaction waits for it
// tick inside the window: accept, bit-serial row multiply, multiply done, then the output load
// tick outside the window or at line end: accept, then the output load
// one item in flight; the output register lets the next item in while a result waits
// rst_n clears state, active flag and output valid at once; configuration registers return to defaults
`include "dda_line_pixel_generator_macros.svh"

module dda_line_pixel_generator #(
    parameter int SCREEN_WIDTH  = dda_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = dda_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRAC_BITS     = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [dda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dda_pkg::CFG_W-1:0]         cfg_data,

    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic signed [dda_pkg::COORD_W-1:0] start_x,
    input  logic signed [dda_pkg::COORD_W-1:0] start_y,
    input  logic signed [dda_pkg::COORD_W-1:0] end_x,
    input  logic signed [dda_pkg::COORD_W-1:0] end_y,
    input  logic [dda_pkg::COLOR_W-1:0]       line_color,

    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              pixel_valid,
    output logic [dda_pkg::OFFSET_W-1:0]      pixel_offset,
    output logic [dda_pkg::COLOR_W-1:0]       pixel_color,
    output logic                              line_done
);

    localparam int CW    = dda_pkg::COORD_W;
    localparam int DVS_W = CW - FRAC_BITS;
    localparam int PX_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int PY_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int PXT_W = PX_W + dda_pkg::STRIDE_W;
    localparam int OW    = dda_pkg::OFFSET_W;

    // window limits in fixed point, held in the offset width
    localparam logic [OW-1:0] WIN_X = OW'(SCREEN_WIDTH) << FRAC_BITS;
    localparam logic [OW-1:0] WIN_Y = OW'(SCREEN_HEIGHT) << FRAC_BITS;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    dda_pkg::state_t                  state_reg, state_next;
    logic                             active_reg;
    logic [dda_pkg::PITCH_W-1:0]      row_pitch_reg;
    logic [dda_pkg::PBITS_W-1:0]      pixel_bits_reg;

    logic [CW-1:0]                    cur_x_reg, cur_y_reg;
    logic [CW-1:0]                    step_x_reg, step_y_reg;
    logic [CW-1:0]                    target_x_reg, target_y_reg;
    logic [dda_pkg::COLOR_W-1:0]      held_color_reg;
    logic                             neg_x_reg, neg_y_reg;
    logic                             mx_zero_reg;
    logic                             res_valid_reg;

    // output register, parts the two channels
    logic                             out_valid_reg;
    logic                             pix_valid_reg;
    logic [OW-1:0]                    pix_offset_reg;
    logic [dda_pkg::COLOR_W-1:0]      pix_color_reg;
    logic                             line_done_reg;

    // ------------------------------------------------------------------
    // handshake terms
    // ------------------------------------------------------------------
    logic in_accept;
    logic out_load;
    logic div_start;
    logic mul_start;

    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == dda_pkg::ST_FIN) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // start: deltas, magnitudes and the larger truncated magnitude
    // ------------------------------------------------------------------
    logic signed [CW:0] dx, dy;
    logic [CW:0]        dx_abs, dy_abs;
    logic [DVS_W-1:0]   ax, ay, mx;

    assign dx     = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    assign dy     = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    assign dx_abs = dx[CW] ? (~dx + 1'b1) : dx;
    assign dy_abs = dy[CW] ? (~dy + 1'b1) : dy;
    assign ax     = dx_abs[CW-1:FRAC_BITS];
    assign ay     = dy_abs[CW-1:FRAC_BITS];
    assign mx     = (ax > ay) ? ax : ay;

    // step division, one lane per axis sharing the divisor
    logic [CW-1:0]      qx, qy;
    dda_pkg::ser_stat_t div_x_stat, div_y_stat;

    dda_div #(
        .DVD_W (CW),
        .DVS_W (DVS_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dx_abs[CW-1:0]),
        .divisor  (mx),
        .quotient (qx),
        .stat     (div_x_stat)
    );

    dda_div #(
        .DVD_W (CW),
        .DVS_W (DVS_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dy_abs[CW-1:0]),
        .divisor  (mx),
        .quotient (qy),
        .stat     (div_y_stat)
    );

    // ------------------------------------------------------------------
    // end test on the current position
    // ------------------------------------------------------------------
    logic signed [CW:0] ex, ey;
    logic [CW:0]        ex_abs, ey_abs;
    logic               at_end;

    assign ex     = {cur_x_reg[CW-1], cur_x_reg} - {target_x_reg[CW-1], target_x_reg};
    assign ey     = {cur_y_reg[CW-1], cur_y_reg} - {target_y_reg[CW-1], target_y_reg};
    assign ex_abs = ex[CW] ? (~ex + 1'b1) : ex;
    assign ey_abs = ey[CW] ? (~ey + 1'b1) : ey;
    assign at_end = (ex_abs[CW:FRAC_BITS] == '0) && (ey_abs[CW:FRAC_BITS] == '0);

    // ------------------------------------------------------------------
    // window test and pixel coordinates
    // ------------------------------------------------------------------
    logic [OW-1:0]                 x_ext, y_ext;
    logic                          in_window;
    logic [PX_W-1:0]               px;
    logic [PY_W-1:0]               py;
    logic [dda_pkg::STRIDE_W-1:0]  stride;
    logic [PXT_W-1:0]              px_term;

    assign x_ext     = OW'(cur_x_reg);
    assign y_ext     = OW'(cur_y_reg);
    assign in_window = !cur_x_reg[CW-1] && !cur_y_reg[CW-1] &&
                       (x_ext < WIN_X) && (y_ext < WIN_Y);
    assign px        = x_ext[FRAC_BITS +: PX_W];
    assign py        = y_ext[FRAC_BITS +: PY_W];
    // byte stride is the bit count over eight
    assign stride    = pixel_bits_reg[dda_pkg::PBITS_W-1:dda_pkg::BYTE_SH];
    assign px_term   = PXT_W'(px) * PXT_W'(stride);

    // pixel offset: row offset plus the column term, one bit of y per cycle
    logic [OW-1:0]      mul_product;
    dda_pkg::ser_stat_t mul_stat;

    dda_mul #(
        .MLT_W (PY_W),
        .MCD_W (dda_pkg::PITCH_W),
        .ACC_W (OW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (row_pitch_reg),
        .mplier  (py),
        .addend  (OW'(px_term)),
        .product (mul_product),
        .stat    (mul_stat)
    );

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dda_pkg::ST_IDLE:
            begin
                priority if (in_accept && req_type == dda_pkg::REQ_START)
                begin
                    state_next = dda_pkg::ST_DIV;
                end
                else if (in_accept && active_reg)
                begin
                    // line end or offscreen pixel needs no multiply
                    state_next = (at_end || !in_window) ? dda_pkg::ST_FIN : dda_pkg::ST_MUL;
                end
                else
                begin
                    state_next = dda_pkg::ST_IDLE;
                end
            end
            dda_pkg::ST_DIV:
            begin
                if (div_x_stat.done)
                begin
                    state_next = dda_pkg::ST_IDLE;
                end
            end
            dda_pkg::ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = dda_pkg::ST_FIN;
                end
            end
            dda_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = dda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dda_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_stall  = (state_reg != dda_pkg::ST_IDLE);
        div_start = 1'b0;
        mul_start = 1'b0;
        if (state_reg == dda_pkg::ST_IDLE && in_valid)
        begin
            div_start = (req_type == dda_pkg::REQ_START);
            mul_start = (req_type == dda_pkg::REQ_TICK) && active_reg && !at_end && in_window;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dda_pkg::ST_IDLE;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            row_pitch_reg  <= dda_pkg::ROW_PITCH_RST;
            pixel_bits_reg <= dda_pkg::PIXEL_BITS_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    dda_pkg::REG_ROW_PITCH:
                    begin
                        row_pitch_reg <= cfg_data[dda_pkg::PITCH_W-1:0];
                    end
                    dda_pkg::REG_PIXEL_BITS:
                    begin
                        pixel_bits_reg <= cfg_data[dda_pkg::PBITS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            // a start replaces any line in progress
            if (div_start)
            begin
                active_reg <= 1'b1;
            end
            else if (out_load && at_end)
            begin
                active_reg <= 1'b0;
            end

            if (in_accept && req_type == dda_pkg::REQ_TICK && active_reg)
            begin
                res_valid_reg <= !at_end && in_window;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // line state and result payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            cur_x_reg      <= start_x;
            cur_y_reg      <= start_y;
            target_x_reg   <= end_x;
            target_y_reg   <= end_y;
            held_color_reg <= line_color;
            neg_x_reg      <= dx[CW];
            neg_y_reg      <= dy[CW];
            mx_zero_reg    <= (mx == '0);
        end
        else if (in_accept && req_type == dda_pkg::REQ_TICK && active_reg && !at_end)
        begin
            // position wraps in coordinate width
            cur_x_reg <= cur_x_reg + step_x_reg;
            cur_y_reg <= cur_y_reg + step_y_reg;
        end

        // steps truncate toward zero; an empty line gets zero steps
        if (state_reg == dda_pkg::ST_DIV && div_x_stat.done)
        begin
            step_x_reg <= mx_zero_reg ? '0 : (neg_x_reg ? (~qx + 1'b1) : qx);
            step_y_reg <= mx_zero_reg ? '0 : (neg_y_reg ? (~qy + 1'b1) : qy);
        end

        // line end is checked on the advanced position
        if (out_load)
        begin
            pix_valid_reg  <= res_valid_reg;
            pix_offset_reg <= res_valid_reg ? mul_product : '0;
            pix_color_reg  <= res_valid_reg ? held_color_reg : '0;
            line_done_reg  <= at_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_valid  = pix_valid_reg;
    assign pixel_offset = pix_offset_reg;
    assign pixel_color  = pix_color_reg;
    assign line_done    = line_done_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `DLPG_ASSERT_IMP(a_blank_payload, out_valid && !pixel_valid, pixel_offset == '0 && pixel_color == '0, "suppressed pixel carries data")
    `DLPG_ASSERT_IMP(a_div_active, state_reg == dda_pkg::ST_DIV, active_reg, "step division without a line")
    `DLPG_ASSERT_IMP(a_mul_inside, state_reg == dda_pkg::ST_MUL, res_valid_reg, "offset multiply for a suppressed pixel")
    `DLPG_ASSERT_NXT(a_idle_tick, in_accept && req_type == dda_pkg::REQ_TICK && !active_reg, state_reg == dda_pkg::ST_IDLE && !active_reg, "idle tick changed state")

endmodule

>>> rtl/dda_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module dda_div #(
    parameter int DVD_W = dda_pkg::COORD_W,
    parameter int DVS_W = dda_pkg::COORD_W - dda_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DVD_W-1:0]      dividend,
    input  logic [DVS_W-1:0]      divisor,
    output logic [DVD_W-1:0]      quotient,
    output dda_pkg::ser_stat_t    stat
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, q_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/dda_mul.sv
// bit-serial shift-add multiplier with a preset addend
module dda_mul #(
    parameter int MLT_W = 10,
    parameter int MCD_W = dda_pkg::PITCH_W,
    parameter int ACC_W = dda_pkg::OFFSET_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [MCD_W-1:0]      mcand,
    input  logic [MLT_W-1:0]      mplier,
    input  logic [ACC_W-1:0]      addend,
    output logic [ACC_W-1:0]      product,
    output dda_pkg::ser_stat_t    stat
);

    localparam int CNT_W = (MLT_W > 1) ? $clog2(MLT_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MLT_W - 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] mcd_reg;
    logic [MLT_W-1:0] mlt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // lsb first: add the shifted multiplicand for each set bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= addend;
            mcd_reg <= ACC_W'(mcand);
            mlt_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (mlt_reg[0])
            begin
                acc_reg <= acc_reg + mcd_reg;
            end
            mcd_reg <= {mcd_reg[ACC_W-2:0], 1'b0};
            mlt_reg <= mlt_reg >> 1;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> bench/dda_line_pixel_generator_tb.sv
// testbench for the dda line pixel generator: pixel scoreboard, transaction drivers and checks
`timescale 1ns / 100ps

module dda_line_pixel_generator_tb;

    localparam int CW    = dda_pkg::COORD_W;
    localparam int PW    = dda_pkg::PITCH_W;
    localparam int BW    = dda_pkg::PBITS_W;
    localparam int CFGW  = dda_pkg::CFG_W;
    localparam int SCR_W = dda_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H = dda_pkg::SCREEN_HEIGHT_DEF;
    localparam int FRAC  = dda_pkg::FRAC_BITS_DEF;

    // a start may still be dividing after the last pixel arrived: the wait covers it plus margin
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 170;

    // one output transaction
    typedef struct packed {
        logic                         valid;
        logic [dda_pkg::OFFSET_W-1:0] offset;
        logic [dda_pkg::COLOR_W-1:0]  color;
        logic                         done;
    } pixel_t;

    // tracks the line walk and holds the pixels still owed by the block
    class pixel_scoreboard;
        logic signed [CW-1:0]        pos_x, pos_y, inc_x, inc_y, goal_x, goal_y;
        logic [dda_pkg::COLOR_W-1:0] line_rgb;
        bit                          walking;
        logic [PW-1:0]               pitch;
        logic [BW-1:0]               bpp;
        pixel_t                      owed[$];
        int                          errors;
        int                          checked;
        int                          lines;

        function new();
            pos_x = '0; pos_y = '0; inc_x = '0; inc_y = '0; goal_x = '0; goal_y = '0;
            line_rgb = '0;
            walking = 1'b0;
            pitch = dda_pkg::ROW_PITCH_RST;
            bpp = dda_pkg::PIXEL_BITS_RST;
            errors = 0;
            checked = 0;
            lines = 0;
        endfunction

        function void write_reg(logic [dda_pkg::CFG_IDX_W-1:0] idx, logic [CFGW-1:0] data);
            if (idx == dda_pkg::REG_ROW_PITCH)
                pitch = data[PW-1:0];
            else if (idx == dda_pkg::REG_PIXEL_BITS)
                bpp = data[BW-1:0];
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // delta over the major span, truncated toward zero
        function logic signed [CW-1:0] axis_step(longint d, longint span);
            longint q;
            if (span == 0)
                return '0;
            q = magnitude(d) / span;
            if (d < 0)
                q = -q;
            return q[CW-1:0];
        endfunction

        function bit at_goal();
            longint ex, ey;
            ex = pos_x - goal_x;
            ey = pos_y - goal_y;
            return ((magnitude(ex) >> FRAC) == 0) && ((magnitude(ey) >> FRAC) == 0);
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void note_input(logic req, logic signed [CW-1:0] sx,
                                 logic signed [CW-1:0] sy, logic signed [CW-1:0] ex,
                                 logic signed [CW-1:0] ey, logic [dda_pkg::COLOR_W-1:0] rgb);
            longint     dx, dy, ax, ay, span, x, y;
            logic [63:0] off;
            pixel_t     pix;
            if (req == dda_pkg::REQ_START)
            begin
                dx = ex - sx;
                dy = ey - sy;
                ax = magnitude(dx) >> FRAC;
                ay = magnitude(dy) >> FRAC;
                span = (ax > ay) ? ax : ay;
                pos_x = sx;
                pos_y = sy;
                goal_x = ex;
                goal_y = ey;
                line_rgb = rgb;
                inc_x = axis_step(dx, span);
                inc_y = axis_step(dy, span);
                walking = 1'b1;
                lines++;
                return;
            end
            if (!walking)
                return;
            pix = '0;
            if (at_goal())
            begin
                pix.done = 1'b1;
                walking = 1'b0;
                owed.push_back(pix);
                return;
            end
            x = pos_x;
            y = pos_y;
            if (x >= 0 && y >= 0 && x < (longint'(SCR_W) << FRAC)
                && y < (longint'(SCR_H) << FRAC))
            begin
                off = (y >> FRAC) * longint'(pitch)
                      + (x >> FRAC) * longint'(bpp >> dda_pkg::BYTE_SH);
                pix.valid = 1'b1;
                pix.offset = off[dda_pkg::OFFSET_W-1:0];
                pix.color = line_rgb;
            end
            pos_x = pos_x + inc_x;
            pos_y = pos_y + inc_y;
            if (at_goal())
            begin
                pix.done = 1'b1;
                walking = 1'b0;
            end
            owed.push_back(pix);
        endfunction

        function void check_result(pixel_t got);
            pixel_t want;
            if (owed.size() == 0)
            begin
                fail($sformatf("unexpected pixel: valid=%b offset=%h color=%h done=%b",
                               got.valid, got.offset, got.color, got.done));
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got.valid !== want.valid || got.offset !== want.offset
                || got.color !== want.color || got.done !== want.done)
                fail($sformatf({"pixel mismatch: expected valid=%b offset=%h color=%h done=%b,",
                                " got valid=%b offset=%h color=%h done=%b"},
                               want.valid, want.offset, want.color, want.done,
                               got.valid, got.offset, got.color, got.done));
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [dda_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [CFGW-1:0]                cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           req_type;
    logic signed [CW-1:0]           start_x;
    logic signed [CW-1:0]           start_y;
    logic signed [CW-1:0]           end_x;
    logic signed [CW-1:0]           end_y;
    logic [dda_pkg::COLOR_W-1:0]    line_color;
    logic                           out_valid;
    logic                           out_stall;
    logic                           pixel_valid;
    logic [dda_pkg::OFFSET_W-1:0]   pixel_offset;
    logic [dda_pkg::COLOR_W-1:0]    pixel_color;
    logic                           line_done;

    pixel_scoreboard board = new();

    // when set, neither side inserts gaps or stalls
    bit steady = 1'b0;
    // starts plus ticks that land on a live line
    int items_counted = 0;
    int settings_used = 0;

    dda_line_pixel_generator #(
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H),
        .FRAC_BITS    (FRAC)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_color  (line_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_valid (pixel_valid),
        .pixel_offset(pixel_offset),
        .pixel_color (pixel_color),
        .line_done   (line_done)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // hard stop in case the block hangs on a handshake
    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    // whole pixels plus 1/256 fractions to fixed point
    function automatic logic signed [CW-1:0] fx(int whole, int frac);
        return CW'((whole <<< FRAC) + frac);
    endfunction

    // output side: stall a random number of cycles before each transaction
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = idle_cycles();
            repeat (n)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // every accepted output transaction goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(pixel_t'{pixel_valid, pixel_offset, pixel_color, line_done});
    end

    // one input transaction after a random gap; returns at the accepting edge
    task automatic send_item(logic req, logic signed [CW-1:0] sx,
                             logic signed [CW-1:0] sy, logic signed [CW-1:0] ex,
                             logic signed [CW-1:0] ey, logic [dda_pkg::COLOR_W-1:0] rgb);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        req_type   = req;
        start_x    = sx;
        start_y    = sy;
        end_x      = ex;
        end_y      = ey;
        line_color = rgb;
        do @(posedge clk); while (in_stall);
        if (req == dda_pkg::REQ_START || board.walking)
            items_counted++;
        board.note_input(req, sx, sy, ex, ey, rgb);
    endtask

    // tick with junk in the unused payload fields
    task automatic send_tick();
        send_item(dda_pkg::REQ_TICK, CW'($urandom), CW'($urandom), CW'($urandom),
                  CW'($urandom), $urandom);
    endtask

    task automatic walk_line(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                             logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                             logic [dda_pkg::COLOR_W-1:0] rgb, int ticks);
        send_item(dda_pkg::REQ_START, sx, sy, ex, ey, rgb);
        repeat (ticks) send_tick();
    endtask

    // wait until every owed pixel is out, then let a pending divide finish
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (board.owed.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(logic [dda_pkg::CFG_IDX_W-1:0] idx, logic [CFGW-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // one random line, usually walked to its end, sometimes cut short by the next start
    task automatic random_line();
        logic signed [CW-1:0] sx, sy, ex, ey;
        int kind, cap, n, reach;
        if ($urandom_range(0, 5) == 0)
            steady = !steady;
        kind = $urandom_range(0, 9);
        sx = fx(int'($urandom_range(0, SCR_W + 32)) - 16, int'($urandom_range(0, 255)));
        sy = fx(int'($urandom_range(0, SCR_H + 32)) - 16, int'($urandom_range(0, 255)));
        cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : 1000;
        if (kind == 0)
        begin
            // anywhere in the coordinate space: huge lines, only a few pixels walked
            sx = CW'($urandom);
            sy = CW'($urandom);
            ex = CW'($urandom);
            ey = CW'($urandom);
            cap = $urandom_range(1, 4);
        end
        else if (kind == 1)
        begin
            // both deltas under one pixel: degenerate line
            ex = CW'(sx + int'($urandom_range(0, 510)) - 255);
            ey = CW'(sy + int'($urandom_range(0, 510)) - 255);
        end
        else
        begin
            if (kind == 2)
            begin
                sx = CW'(int'($urandom_range(0, 16720000)) - 8360000);
                sy = CW'(int'($urandom_range(0, 16720000)) - 8360000);
            end
            reach = (kind == 3) ? 64 : 20;
            ex = CW'(sx + int'($urandom_range(0, 2 * (reach << FRAC))) - (reach << FRAC));
            ey = CW'(sy + int'($urandom_range(0, 2 * (reach << FRAC))) - (reach << FRAC));
        end
        send_item(dda_pkg::REQ_START, sx, sy, ex, ey, $urandom);
        for (n = 0; n < cap && board.walking; n++)
            send_tick();
        // sometimes one or two extra ticks; once the line has ended the block ignores them
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_tick();
    endtask

    // minor delta of one pixel over a 258 pixel span: the minor step truncates to zero,
    // so the walk passes the endpoint and keeps going until the next start
    task automatic overshoot_line();
        logic signed [CW-1:0] sx, sy, ex, ey;
        int dy;
        sx = fx(int'($urandom_range(0, 700)), int'($urandom_range(0, 255)));
        sy = fx(int'($urandom_range(2, SCR_H - 2)), int'($urandom_range(0, 255)));
        dy = 256 + int'($urandom_range(0, 1));
        ex = CW'(sx + (258 <<< FRAC) + int'($urandom_range(0, 255)));
        ey = ($urandom_range(0, 1) == 0) ? CW'(sy + dy) : CW'(sy - dy);
        walk_line(sx, sy, ex, ey, $urandom, 264);
    endtask

    initial
    begin
        logic [PW-1:0] pitch;
        logic [BW-1:0] bpp;
        int            goal;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = dda_pkg::REG_ROW_PITCH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = dda_pkg::REQ_START;
        start_x    = '0;
        start_y    = '0;
        end_x      = '0;
        end_y      = '0;
        line_color = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lines under the reset register values
        settings_used++;
        send_tick();                                               // no line yet: ignored
        walk_line(fx(10, 128), fx(20, 64), fx(10, 128), fx(20, 64), '1, 2); // empty line
        walk_line(fx(0, 0), fx(0, 0), fx(4, 0), fx(0, 0), '0, 4);  // one pixel per step
        // walking left and down across the bottom edge of the window
        walk_line(fx(1023, 255), fx(1023, 255), fx(1020, 255), fx(1026, 1), 32'h1234_5678, 3);
        // entering the window from negative coordinates
        walk_line(fx(-2, 0), fx(-1, 0), fx(2, 0), fx(1, 0), 32'h00FF_FF00, 4);
        // coordinate extremes, interrupted by the next start
        walk_line(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 32'hA5A5_A5A5, 2);
        // leaving through the right edge of the window
        walk_line(fx(1022, 0), fx(5, 0), fx(1025, 0), fx(5, 0), 32'h8000_0001, 3);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    pitch = '0;
                    bpp = 7'd8;
                end
                1:
                begin
                    pitch = '1;
                    bpp = 7'd64;
                end
                4:
                begin
                    pitch = 16'd7680;
                    bpp = 7'd24;
                end
                default:
                begin
                    pitch = PW'($urandom);
                    bpp = BW'($urandom_range(8, 64));
                end
            endcase
            set_register(dda_pkg::REG_ROW_PITCH, CFGW'(pitch));
            set_register(dda_pkg::REG_PIXEL_BITS, CFGW'(bpp));
            settings_used++;
            goal = items_counted + PHASE_ITEMS;
            if (p == 2)
                overshoot_line();
            while (items_counted < goal)
                random_line();
            settle();
        end

        if (board.owed.size() != 0)
            board.fail($sformatf("%0d pixels never arrived", board.owed.size()));

        $display("summary: %0d lines started, %0d pixel transactions checked",
                 board.lines, board.checked);
        $display("summary: %0d register settings, %0d failures", settings_used, board.errors);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
